@@ sv/dlq_pkg.sv @@
package dlq_pkg;

    // Command codes carried in the cmd field of an input word.
    localparam logic [1:0] CMD_UPLOAD   = 2'd0;
    localparam logic [1:0] CMD_TICK     = 2'd1;
    localparam logic [1:0] CMD_DOWNLOAD = 2'd2;

    // Packet types below this value have a counter of their own.
    localparam logic [2:0] NUM_COUNTED_TYPES = 3'd4;

    localparam int DEFAULT_QUEUE_DEPTH = 16;

    localparam logic [15:0] LINK_DELAY_RESET = 16'd1;

    // Ages are stored biased by one so that a fresh upload from end A (age -1)
    // is zero. The biased age saturates at 65536, which is age 65535.
    localparam logic [16:0] AGE_P1_MAX  = 17'h10000;
    localparam logic [16:0] AGE_P1_ENDA = 17'd0;
    localparam logic [16:0] AGE_P1_ENDB = 17'd1;

    typedef struct packed {
        logic [1:0]  cmd;
        logic        side;
        logic [15:0] pkt_handle;
        logic [2:0]  pkt_type;
    } t_in_word;

    typedef struct packed {
        logic        ok;
        logic [15:0] out_handle;
        logic [2:0]  out_type;
        logic [31:0] request_count;
        logic [31:0] reply_count;
        logic [31:0] data_count;
        logic [31:0] ack_count;
    } t_out_word;

    // One queue slot as held in the slot memory.
    typedef struct packed {
        logic [2:0]  pkt_type;
        logic [15:0] pkt_handle;
        logic [16:0] age_p1;
    } t_slot;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic push;
        logic rd_slot;
        logic tick_wr;
        logic pop;
        logic res_set;
        logic res_ok;
        logic res_deliver;
        logic out_load;
    } t_dp_ctl;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [1:0] cmd;
        logic       q_empty;
        logic       q_full;
        logic       head_ripe;
        logic       tick_done;
    } t_dp_stat;

endpackage

@@ sv/dlq_datapath.sv @@
module dlq_datapath import dlq_pkg::*; #(
    parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_in_word    i_in_word,
    input  logic        i_cfg_wr_en,
    input  logic [15:0] i_cfg_wr_data,
    input  t_dp_ctl     i_ctl,
    output t_dp_stat    o_stat,
    output t_out_word   o_out_word
);

    localparam int PTR_W     = $clog2(QUEUE_DEPTH);
    localparam int CNT_W     = $clog2(QUEUE_DEPTH + 1);
    localparam int MEM_DEPTH = 2 ** (PTR_W + 1);
    localparam logic [PTR_W:0]   DEPTH_S = (PTR_W + 1)'(QUEUE_DEPTH);
    localparam logic [CNT_W-1:0] FULL_C  = CNT_W'(QUEUE_DEPTH);

    // Reduce a sum below twice the depth to a slot index.
    function automatic logic [PTR_W-1:0] f_wrap(input logic [PTR_W:0] s);
        if (s >= DEPTH_S) begin
            return PTR_W'(s - DEPTH_S);
        end
        return s[PTR_W-1:0];
    endfunction

    t_in_word         r_item;
    logic [15:0]      r_link_delay;
    logic [PTR_W-1:0] r_head [2];
    logic [CNT_W-1:0] r_fill [2];
    logic [CNT_W-1:0] r_k;
    logic [31:0]      r_cnt [4];
    t_slot            r_mem [MEM_DEPTH];
    t_slot            r_rd_data;
    logic [PTR_W:0]   r_wr_addr;
    logic             r_res_ok;
    logic [15:0]      r_res_handle;
    logic [2:0]       r_res_type;
    t_out_word        r_out;

    logic             q;
    logic [PTR_W-1:0] rd_slot;
    logic [PTR_W-1:0] tail_slot;
    logic [PTR_W:0]   rd_addr;
    logic [PTR_W:0]   wr_addr;
    logic             wr_en;
    t_slot            wr_data;
    logic [PTR_W-1:0] head_next;

    // Uploads go into the queue the acting end sends on; ticks and downloads
    // work on the queue the acting end receives from.
    assign q = (r_item.cmd == CMD_UPLOAD) ? r_item.side : ~r_item.side;

    assign rd_slot   = f_wrap({1'b0, r_head[q]} + {1'b0, r_k[PTR_W-1:0]});
    assign tail_slot = f_wrap({1'b0, r_head[q]} + {1'b0, r_fill[q][PTR_W-1:0]});
    assign rd_addr   = {q, rd_slot};
    assign head_next = (r_head[q] == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_head[q] + 1'b1;

    always_comb begin
        wr_en   = i_ctl.push | i_ctl.tick_wr;
        wr_addr = r_wr_addr;
        wr_data = r_rd_data;
        if (i_ctl.push) begin
            wr_addr            = {q, tail_slot};
            wr_data.pkt_type   = r_item.pkt_type;
            wr_data.pkt_handle = r_item.pkt_handle;
            wr_data.age_p1     = r_item.side ? AGE_P1_ENDB : AGE_P1_ENDA;
        end else if (r_rd_data.age_p1 != AGE_P1_MAX) begin
            wr_data.age_p1 = r_rd_data.age_p1 + 17'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (i_ctl.rd_slot) begin
            r_rd_data <= r_mem[rd_addr];
            r_wr_addr <= rd_addr;
        end
        if (i_ctl.capture) begin
            r_item <= i_in_word;
        end
        if (i_ctl.res_set) begin
            r_res_ok     <= i_ctl.res_ok;
            r_res_handle <= i_ctl.res_deliver ? r_rd_data.pkt_handle : 16'd0;
            r_res_type   <= i_ctl.res_deliver ? r_rd_data.pkt_type : 3'd0;
        end
        if (i_ctl.out_load) begin
            r_out.ok            <= r_res_ok;
            r_out.out_handle    <= r_res_handle;
            r_out.out_type      <= r_res_type;
            r_out.request_count <= r_cnt[0];
            r_out.reply_count   <= r_cnt[1];
            r_out.data_count    <= r_cnt[2];
            r_out.ack_count     <= r_cnt[3];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_link_delay <= LINK_DELAY_RESET;
            r_head       <= '{default: '0};
            r_fill       <= '{default: '0};
            r_cnt        <= '{default: '0};
            r_k          <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_link_delay <= i_cfg_wr_data;
            end
            if (i_ctl.capture) begin
                r_k <= '0;
            end else if (i_ctl.rd_slot) begin
                r_k <= r_k + 1'b1;
            end
            if (i_ctl.push) begin
                r_fill[q] <= r_fill[q] + 1'b1;
                if (r_item.pkt_type < NUM_COUNTED_TYPES) begin
                    r_cnt[r_item.pkt_type[1:0]] <= r_cnt[r_item.pkt_type[1:0]] + 32'd1;
                end
            end
            if (i_ctl.pop) begin
                r_fill[q] <= r_fill[q] - 1'b1;
                r_head[q] <= head_next;
            end
        end
    end

    assign o_stat.cmd       = r_item.cmd;
    assign o_stat.q_empty   = (r_fill[q] == '0);
    assign o_stat.q_full    = (r_fill[q] == FULL_C);
    assign o_stat.head_ripe = (r_rd_data.age_p1 > {1'b0, r_link_delay});
    assign o_stat.tick_done = (r_k == r_fill[q]);
    assign o_out_word       = r_out;

endmodule

@@ sv/dlq_ctrl.sv @@
module dlq_ctrl import dlq_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    output logic     o_out_valid,
    input  logic     i_out_stall,
    input  t_dp_stat i_stat,
    output t_dp_ctl  o_ctl
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_TICK,
        S_POP,
        S_DONE
    } t_state;

    t_state r_state;
    logic   r_out_valid;

    always_comb begin
        o_ctl = '0;
        unique case (r_state)
            S_IDLE: begin
                o_ctl.capture = i_in_valid;
            end
            S_EXEC: begin
                unique case (i_stat.cmd)
                    CMD_UPLOAD: begin
                        o_ctl.push    = !i_stat.q_full;
                        o_ctl.res_set = 1'b1;
                        o_ctl.res_ok  = !i_stat.q_full;
                    end
                    CMD_TICK, CMD_DOWNLOAD: begin
                        o_ctl.rd_slot = !i_stat.q_empty;
                        o_ctl.res_set = i_stat.q_empty;
                    end
                    default: begin
                        o_ctl.res_set = 1'b1;
                    end
                endcase
            end
            S_TICK: begin
                // Write back the slot read last cycle and read the next one.
                o_ctl.tick_wr = 1'b1;
                o_ctl.rd_slot = !i_stat.tick_done;
                o_ctl.res_set = i_stat.tick_done;
                o_ctl.res_ok  = 1'b1;
            end
            S_POP: begin
                o_ctl.res_set     = 1'b1;
                o_ctl.pop         = i_stat.head_ripe;
                o_ctl.res_ok      = i_stat.head_ripe;
                o_ctl.res_deliver = i_stat.head_ripe;
            end
            S_DONE: begin
                o_ctl.out_load = !r_out_valid || !i_out_stall;
            end
            default: begin
                o_ctl = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (o_ctl.out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (o_ctl.capture) begin
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    if (o_ctl.res_set) begin
                        r_state <= S_DONE;
                    end else if (i_stat.cmd == CMD_TICK) begin
                        r_state <= S_TICK;
                    end else begin
                        r_state <= S_POP;
                    end
                end
                S_TICK: begin
                    if (i_stat.tick_done) begin
                        r_state <= S_DONE;
                    end
                end
                S_POP: begin
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (o_ctl.out_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

@@ sv/duplex_link_delay_queue.sv @@
// Two-way link delay queue. Each direction of the link is a FIFO of
// QUEUE_DEPTH packet slots, and every slot carries an age counted in
// propagation ticks. An upload from end A enters the A-to-B queue with age -1,
// an upload from end B enters the B-to-A queue with age 0, and an accepted
// upload of type route request, route reply, data or ack bumps its 32-bit
// wrapping counter. A tick for one end ages every packet that end receives,
// saturating at 65535, and a download for one end delivers the head packet of
// its receive queue once that packet's age has reached link_delay. Every input
// word yields exactly one output word, which carries the counter values after
// the command. The block works on one word at a time: an upload or an unused
// command goes through decode and the result hand-off, a download also through
// the head check and a tick also through the aging loop between them, unless
// the queue is empty. The ages live in a single slot memory with one read and
// one write port and are read, incremented and written back one slot per
// cycle. A result waits in an output register, so a stalled consumer holds
// the block in its final step without losing the word. The link_delay
// register resets to 1 and may be written only while the block is idle. No
// clearing pass is needed after reset.
module duplex_link_delay_queue import dlq_pkg::*; #(
    parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in_word    i_in_word,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_word   o_out_word,
    input  logic        i_cfg_wr_en,
    input  logic [15:0] i_cfg_wr_data
);

    // Commands and status between the sequencer and the queue datapath.
    t_dp_ctl  ctl;
    t_dp_stat stat;

    // The sequencer owns both handshakes and steps each command through
    // decode, the per-slot aging loop or the head check, and the result hand-off.
    dlq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_stat      (stat),
        .o_ctl       (ctl)
    );

    // The datapath holds the slot memory for both directions, the head
    // pointers and fill counts, the type counters and the output register.
    dlq_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_word     (i_in_word),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_ctl         (ctl),
        .o_stat        (stat),
        .o_out_word    (o_out_word)
    );

endmodule

@@ sv/dlq_checker.sv @@
module dlq_checker import dlq_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input t_out_word   o_out_word
);

    // A word held back by the consumer stays valid and unchanged.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_word)))
        else $error("stalled output word changed or dropped");

    // The block works on one word at a time, so an accepted word blocks the next.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input accepted while previous word still in progress");

    // A failed command delivers no packet fields.
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_word.ok) |->
            (o_out_word.out_handle == 16'd0 && o_out_word.out_type == 3'd0))
        else $error("packet fields nonzero on a failed command");

endmodule

bind duplex_link_delay_queue dlq_checker u_dlq_checker (.*);

@@ bench/dlq_link_checker.sv @@
module dlq_link_checker import dlq_pkg::*; #(
    parameter int DEPTH = DEFAULT_QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  t_in_word    i_in_word,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  t_out_word   i_out_word,
    input  logic        i_cfg_wr_en,
    input  logic [15:0] i_cfg_wr_data,
    output int          o_fail_count,
    output int          o_pending
);

    localparam int AGE_LIMIT  = 65535;
    localparam int AGE_FROM_A = -1;
    localparam int AGE_FROM_B = 0;

    typedef struct {
        logic [15:0] handle;
        logic [2:0]  ptype;
        int          age;
    } t_link_pkt;

    // Packets in flight, indexed by the end that sent them: entry 0 is the
    // A-to-B direction and entry 1 the B-to-A direction.
    t_link_pkt   in_flight [2][$];
    logic [31:0] type_count [4];
    logic [15:0] link_delay;
    t_out_word   due_words [$];
    int          fails = 0;

    function automatic t_out_word advance_link(input t_in_word w);
        t_out_word r;
        t_link_pkt p;
        int        src;
        r = '0;
        // An end receives from the direction the other end sends into.
        src = w.side ? 0 : 1;
        case (w.cmd)
            CMD_UPLOAD: begin
                if (in_flight[w.side].size() < DEPTH) begin
                    p.handle = w.pkt_handle;
                    p.ptype  = w.pkt_type;
                    p.age    = w.side ? AGE_FROM_B : AGE_FROM_A;
                    in_flight[w.side].push_back(p);
                    r.ok = 1'b1;
                    if (w.pkt_type < NUM_COUNTED_TYPES) begin
                        type_count[w.pkt_type[1:0]] = type_count[w.pkt_type[1:0]] + 32'd1;
                    end
                end
            end
            CMD_TICK: begin
                if (in_flight[src].size() > 0) begin
                    r.ok = 1'b1;
                    for (int k = 0; k < in_flight[src].size(); k++) begin
                        if (in_flight[src][k].age < AGE_LIMIT) begin
                            in_flight[src][k].age = in_flight[src][k].age + 1;
                        end
                    end
                end
            end
            CMD_DOWNLOAD: begin
                if (in_flight[src].size() > 0 && in_flight[src][0].age >= int'(link_delay)) begin
                    p = in_flight[src].pop_front();
                    r.ok         = 1'b1;
                    r.out_handle = p.handle;
                    r.out_type   = p.ptype;
                end
            end
            default: begin
            end
        endcase
        r.request_count = type_count[0];
        r.reply_count   = type_count[1];
        r.data_count    = type_count[2];
        r.ack_count     = type_count[3];
        return r;
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fails++;
        end
    endfunction

    always @(posedge i_clk) begin : watch
        t_out_word want;
        if (!i_rst_n) begin
            in_flight[0].delete();
            in_flight[1].delete();
            due_words.delete();
            for (int k = 0; k < 4; k++) begin
                type_count[k] = '0;
            end
            link_delay = LINK_DELAY_RESET;
        end else begin
            if (i_cfg_wr_en) begin
                link_delay = i_cfg_wr_data;
            end
            // A result always belongs to a word accepted at an earlier edge,
            // so it is matched before this edge's word is predicted.
            if (i_out_valid && !i_out_stall) begin
                if (due_words.size() == 0) begin
                    $error("result word arrived with nothing expected");
                    fails++;
                end else begin
                    want = due_words.pop_front();
                    check_field("ok", 32'(want.ok), 32'(i_out_word.ok));
                    check_field("out_handle", 32'(want.out_handle),
                                32'(i_out_word.out_handle));
                    check_field("out_type", 32'(want.out_type), 32'(i_out_word.out_type));
                    check_field("request_count", want.request_count,
                                i_out_word.request_count);
                    check_field("reply_count", want.reply_count, i_out_word.reply_count);
                    check_field("data_count", want.data_count, i_out_word.data_count);
                    check_field("ack_count", want.ack_count, i_out_word.ack_count);
                end
            end
            if (i_in_valid && !i_in_stall) begin
                due_words.push_back(advance_link(i_in_word));
            end
        end
        o_pending    = due_words.size();
        o_fail_count = fails;
    end

endmodule

@@ bench/tb_top.sv @@
// Stimulus and verdict for the duplex link delay queue. A checker beside the
// block watches both channels, predicts every result word and counts
// mismatches; this module only produces traffic and reports the outcome.
module tb_top import dlq_pkg::*;;

    localparam logic       SIDE_A      = 1'b0;
    localparam logic       SIDE_B      = 1'b1;
    localparam logic [1:0] CMD_UNUSED  = 2'd3;
    localparam int         DEPTH       = DEFAULT_QUEUE_DEPTH;
    localparam int         HOLD_CYCLES = 400;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_TOGGLE
    } t_stall_mode;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    t_in_word    in_word;
    logic        out_valid;
    logic        out_stall = 1'b0;
    t_out_word   out_word;
    logic        cfg_wr_en;
    logic [15:0] cfg_wr_data;

    int          fail_count;
    int          pending;
    int          words_sent;
    int          burst_left;
    logic [15:0] cur_delay;
    int          hold_asked = 0;
    int          hold_done  = 0;

    duplex_link_delay_queue #(
        .QUEUE_DEPTH(DEPTH)
    ) uut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .o_in_stall   (in_stall),
        .i_in_word    (in_word),
        .o_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .o_out_word   (out_word),
        .i_cfg_wr_en  (cfg_wr_en),
        .i_cfg_wr_data(cfg_wr_data)
    );

    dlq_link_checker #(
        .DEPTH(DEPTH)
    ) link_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_word    (in_word),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_word   (out_word),
        .i_cfg_wr_en  (cfg_wr_en),
        .i_cfg_wr_data(cfg_wr_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Safety net: even with every word a tick over a full queue and the
    // receiver stalling heavily, a correct run finishes well inside this bound.
    initial begin
        #5_000_000;
        $display("simulation failed");
        $finish;
    end

    // Offers one word and holds it until the block takes it. The sender works
    // in bursts; when a burst is used up a random gap of idle cycles is put in
    // front of the next word, and some bursts start without any gap at all.
    task automatic send_word(input t_in_word w);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            repeat (gap) begin
                @(negedge clk);
                in_valid <= 1'b0;
            end
        end
        burst_left--;
        @(negedge clk);
        in_valid <= 1'b1;
        in_word  <= w;
        @(posedge clk);
        while (in_stall) begin
            @(posedge clk);
        end
        words_sent++;
    endtask

    function automatic t_in_word make_word(logic [1:0] cmd, logic side,
                                           logic [15:0] handle, logic [2:0] ptype);
        t_in_word w;
        w.cmd        = cmd;
        w.side       = side;
        w.pkt_handle = handle;
        w.pkt_type   = ptype;
        return w;
    endfunction

    task automatic upload(input logic side, input logic [15:0] handle, input logic [2:0] ptype);
        send_word(make_word(CMD_UPLOAD, side, handle, ptype));
    endtask

    // Ticks and downloads carry random handle and type bits, which the block
    // must ignore.
    task automatic tick(input logic side);
        send_word(make_word(CMD_TICK, side, 16'($urandom), 3'($urandom_range(0, 7))));
    endtask

    task automatic download(input logic side);
        send_word(make_word(CMD_DOWNLOAD, side, 16'($urandom), 3'($urandom_range(0, 7))));
    endtask

    task automatic noise_word();
        send_word(make_word(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                            16'($urandom), 3'($urandom_range(0, 7))));
    endtask

    // Stops offering and waits until every expected result word is back.
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        wait (pending == 0);
    endtask

    // The delay register may only change while the block is idle, so the
    // pipeline is emptied first.
    task automatic set_delay(input logic [15:0] delay);
        drain();
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= delay;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        cur_delay = delay;
    endtask

    // A well-formed exchange: a few packets go one way, the receiving end
    // ticks them until they are ripe (with early download attempts mixed in),
    // then downloads them all plus one more to hit the empty queue.
    task automatic flight(input logic up_side);
        int n_pkts;
        int n_ticks;
        n_pkts = $urandom_range(1, 6);
        repeat (n_pkts) upload(up_side, 16'($urandom), 3'($urandom_range(0, 7)));
        n_ticks = int'(cur_delay) + ((up_side == SIDE_A) ? 1 : 0) + $urandom_range(0, 2);
        repeat (n_ticks) begin
            tick(!up_side);
            if ($urandom_range(0, 2) == 0) begin
                download(!up_side);
            end
        end
        repeat (n_pkts + 1) download(!up_side);
    endtask

    // Overfills one direction so that uploads get rejected, then empties it
    // again when the delay is short enough to reach.
    task automatic fill_side(input logic up_side);
        repeat (DEPTH + $urandom_range(1, 3)) begin
            upload(up_side, 16'($urandom), 3'($urandom_range(0, 7)));
        end
        if (cur_delay <= 8) begin
            repeat (int'(cur_delay) + 2) tick(!up_side);
        end
        repeat (DEPTH + 1) download(!up_side);
    endtask

    // Mostly well-formed flights, with fills and bursts of arbitrary words
    // (the unused command among them) mixed in.
    task automatic random_phase(input int n_words);
        int stop_at;
        stop_at = words_sent + n_words;
        while (words_sent < stop_at) begin
            case ($urandom_range(0, 9))
                0, 1: begin
                    repeat ($urandom_range(1, 6)) noise_word();
                end
                2: begin
                    fill_side(1'($urandom_range(0, 1)));
                end
                default: begin
                    if (cur_delay <= 8) begin
                        flight(1'($urandom_range(0, 1)));
                    end else begin
                        noise_word();
                    end
                end
            endcase
        end
    endtask

    // Receiver back-pressure. It switches at random between stall patterns, and
    // on request it holds off for a long stretch so that the block's output
    // register stays full and the input side backs up.
    initial begin : stall_pattern
        t_stall_mode mode;
        int          mode_left;
        int          hold_left;
        mode      = STALL_NONE;
        mode_left = 0;
        hold_left = 0;
        forever begin
            @(negedge clk);
            if (hold_asked != hold_done) begin
                hold_done = hold_asked;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end else begin
                if (mode_left == 0) begin
                    mode      = t_stall_mode'($urandom_range(0, 3));
                    mode_left = $urandom_range(5, 60);
                end
                mode_left--;
                case (mode)
                    STALL_NONE:   out_stall <= 1'b0;
                    STALL_LIGHT:  out_stall <= ($urandom_range(0, 3) == 0);
                    STALL_HEAVY:  out_stall <= ($urandom_range(0, 3) != 0);
                    STALL_TOGGLE: out_stall <= !out_stall;
                    default:      out_stall <= 1'b0;
                endcase
            end
        end
    end

    initial begin
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        in_word     = '0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        words_sent  = 0;
        burst_left  = 0;
        cur_delay   = LINK_DELAY_RESET;
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;

        // Directed part, starting from the reset delay of one tick.
        // Both receive queues are empty: a download and a tick both fail.
        download(SIDE_A);
        tick(SIDE_B);
        send_word(make_word(CMD_UNUSED, SIDE_B, 16'hFFFF, 3'd7));
        // Extreme handles, an uncounted type and the route request type.
        upload(SIDE_A, 16'hFFFF, 3'd7);
        upload(SIDE_B, 16'h0000, 3'd0);
        // Neither packet is old enough yet; the one from end A starts at -1.
        download(SIDE_B);
        download(SIDE_A);
        tick(SIDE_B);
        download(SIDE_B);
        tick(SIDE_B);
        download(SIDE_B);
        tick(SIDE_A);
        download(SIDE_A);
        // The remaining types in both directions, with alternating bit patterns.
        upload(SIDE_A, 16'h5555, 3'd1);
        upload(SIDE_B, 16'hAAAA, 3'd2);
        upload(SIDE_A, 16'hAAAA, 3'd3);
        upload(SIDE_B, 16'h5555, 3'd4);
        upload(SIDE_A, 16'h0F0F, 3'd5);
        upload(SIDE_B, 16'hF0F0, 3'd6);
        // With no delay at all, a packet from end A still needs one tick.
        set_delay(16'd0);
        upload(SIDE_A, 16'h1234, 3'd3);
        download(SIDE_B);
        tick(SIDE_B);
        download(SIDE_B);

        // Random part across several delay settings.
        random_phase(250);
        set_delay(16'd2);
        // Long receiver hold-off while the sender keeps offering words.
        hold_asked = hold_asked + 1;
        random_phase(300);
        set_delay(16'hFFFF);
        random_phase(100);
        set_delay(16'd1);
        random_phase(300);
        set_delay(16'd3);
        random_phase(250);
        set_delay(16'($urandom_range(0, 5)));
        random_phase(250);
        set_delay(16'd0);
        random_phase(200);

        // Let the last results come back and give stray words time to show.
        drain();
        repeat (20) @(posedge clk);
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

@@ sim.f @@
sv/dlq_pkg.sv
sv/dlq_datapath.sv
sv/dlq_ctrl.sv
sv/duplex_link_delay_queue.sv
sv/dlq_checker.sv
bench/dlq_link_checker.sv
bench/tb_top.sv
